// ----- src/face_unit_normal_macros.svh -----
// Assertion helpers for the file that checks this block.
`ifndef FACE_UNIT_NORMAL_MACROS_SVH
`define FACE_UNIT_NORMAL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FUN_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FUN_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

// ----- src/fun_pkg.sv -----
package fun_pkg;

	localparam int CW  = 16;          // coordinate width, signed Q8.8
	localparam int NF  = 14;          // fraction bits of the normal
	localparam int EW  = CW + 1;      // edge vector component
	localparam int PW  = 2 * EW;      // edge product
	localparam int XW  = PW + 2;      // cross product component, signed
	localparam int MGW = PW;          // cross product magnitude
	localparam int MW  = 31;          // normalized magnitude
	localparam int SW  = 64;          // sum of squares
	localparam int RW  = 32;          // square root
	localparam int DNW = MW + NF + 1; // dividend
	localparam int QW  = 16;          // quotient
	localparam int OW  = 16;          // output component
	localparam int LW  = 40;          // degenerate limit
	localparam int SMALL_BITS = 20;   // exact degenerate test applies below this length
	localparam int IN_W  = 160;
	localparam int OUT_W = 48;

	typedef struct packed {
		logic       load;
		logic       cross_en;
		logic [2:0] sel;
		logic       mag_load;
		logic       acc_clr;
		logic       sq_en;
		logic       norm_step;
		logic       sqrt_clr;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		logic [1:0] comp;
		logic       finish;
		logic       skip;
	} fun_cmd_t;

	typedef struct packed {
		logic pts_ok;
		logic nz;
		logic small_len;
		logic deg;
		logic norm_done;
	} fun_sts_t;

endpackage

// ----- src/face_unit_normal.sv -----
// Polygon face normal unit.
// The slave stream takes one request per face: tdata carries the point count,
// then vertex 0, vertex 1 and the last vertex (x, y, z each), and tlast marks
// the last face of an object. The master stream returns one result per
// request: the unit normal in signed Q1.14 in tdata and two flags in tuser.
// The degenerate limit is written through the register port at address 0.
// One face is worked on at a time. A face with fewer than three points or a
// zero cross product is skipped once the cross products are done, a face
// found degenerate after its sum of squares, and a full face also takes up to
// 30 one-bit normalizing shifts, 32 steps of the bit-serial square root and
// three 16-step restoring divisions through one shared divider.
// The finished result sits in the output register, so the next request is
// taken while it waits; when the receiver stalls, the following face holds
// in its last cycle until the output register is free.
// Reset empties the output, sets the limit to 1 and clears the stored normal.
`include "face_unit_normal_macros.svh"

module face_unit_normal import fun_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// face_points, first_x/y/z, second_x/y/z, final_x/y/z
	input  logic [IN_W-1:0]   s_tdata,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	// normal_x, normal_y, normal_z
	output logic [OUT_W-1:0]  m_tdata,
	// skipped, normal_changed
	output logic [1:0]        m_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	fun_cmd_t        cmd;
	fun_sts_t        sts;
	logic [LW-1:0]   limit_q;

	assign pready = 1'b1;
	assign prdata = paddr[3] ? 64'd0 : 64'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LW'(1);
		end else if (psel && penable && pwrite && pready && !paddr[3]) begin
			limit_q <= pwdata[LW-1:0];
		end
	end

	fun_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fun_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.in_last  (s_tlast),
		.limit    (limit_q),
		.out_data (m_tdata),
		.out_user (m_tuser)
	);

	`FUN_ASSERT_NOW(a_skip_zero, m_tvalid && m_tuser[0], m_tdata == 48'd0 && !m_tuser[1], "skipped face carries a normal")
	`FUN_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "second request taken while busy")
	`FUN_ASSERT_NOW(a_norm_range, m_tvalid && !m_tuser[0], $signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384, "normal x out of range")

endmodule

// ----- src/fun_datapath.sv -----
module fun_datapath import fun_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fun_cmd_t         cmd,
	output fun_sts_t         sts,
	input  logic [IN_W-1:0]  in_data,
	input  logic             in_last,
	input  logic [LW-1:0]    limit,
	output logic [OUT_W-1:0] out_data,
	output logic [1:0]       out_user
);

	logic                   pts_ok_q, last_q;
	logic signed [EW-1:0]   ea_q [3];
	logic signed [EW-1:0]   eb_q [3];
	logic signed [EW-1:0]   ea_d [3];
	logic signed [EW-1:0]   eb_d [3];
	logic signed [EW-1:0]   mul_a, mul_b;
	logic signed [PW-1:0]   prod_s1;
	logic                   cross_vld_s1;
	logic [2:0]             cross_sel_s1;
	logic signed [XW-1:0]   n_q [3];
	logic signed [XW-1:0]   nabs;
	logic [MGW-1:0]         mag_q [3];
	logic [MGW-1:0]         mag_d [3];
	logic                   neg_q [3];
	logic [MGW-1:0]         or_w;
	logic [MW-1:0]          sq_op;
	logic [2*MW-1:0]        sq_s1;
	logic                   sq_vld_s1;
	logic [SW-1:0]          acc_q;
	logic [RW-1:0]          root_q;
	logic [RW+1:0]          srem_q;
	logic [RW+2:0]          st, strial;
	logic [DNW-1:0]         num;
	logic [RW-1:0]          drem_q;
	logic [QW-1:0]          dlow_q, q_q;
	logic [RW:0]            dt;
	logic [OW-1:0]          res_q [3];
	logic [OW-1:0]          prev_q [3];
	logic [OW-1:0]          outn_q [3];
	logic                   skipped_q, changed_q, differ;

	// Input fields from the lowest bit: points, v0 xyz, v1 xyz, vlast xyz.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ea_d[i] = EW'($signed(in_data[64+16*i +: CW])) - EW'($signed(in_data[16+16*i +: CW]));
			eb_d[i] = EW'($signed(in_data[112+16*i +: CW])) - EW'($signed(in_data[16+16*i +: CW]));
		end
	end

	// Cross product terms, one product per cycle.
	always_comb begin
		case (cmd.sel)
			3'd0: begin mul_a = ea_q[1]; mul_b = eb_q[2]; end
			3'd1: begin mul_a = ea_q[2]; mul_b = eb_q[1]; end
			3'd2: begin mul_a = ea_q[2]; mul_b = eb_q[0]; end
			3'd3: begin mul_a = ea_q[0]; mul_b = eb_q[2]; end
			3'd4: begin mul_a = ea_q[0]; mul_b = eb_q[1]; end
			3'd5: begin mul_a = ea_q[1]; mul_b = eb_q[0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nabs = n_q[i][XW-1] ? -n_q[i] : n_q[i];
			mag_d[i] = MGW'(nabs);
		end
	end

	assign or_w  = mag_q[0] | mag_q[1] | mag_q[2];
	assign sq_op = mag_q[cmd.sel[1:0]][MW-1:0];

	assign st     = {srem_q[RW:0], acc_q[SW-1 -: 2]};
	assign strial = {1'b0, root_q, 2'b01};
	assign num    = DNW'({mag_q[cmd.comp][MW-1:0], NF'(0)}) + DNW'(root_q[RW-1:1]);
	assign dt     = {drem_q, dlow_q[QW-1]};

	assign differ = (res_q[0] != prev_q[0]) || (res_q[1] != prev_q[1]) ||
	                (res_q[2] != prev_q[2]);

	assign sts.pts_ok    = pts_ok_q;
	assign sts.nz        = |or_w;
	assign sts.small_len = ~|or_w[MGW-1:SMALL_BITS];
	assign sts.deg       = acc_q < SW'(limit);
	assign sts.norm_done = ~|or_w[MGW-1:MW] & or_w[MW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_vld_s1 <= 1'b0;
			sq_vld_s1    <= 1'b0;
			for (int i = 0; i < 3; i++) prev_q[i] <= '0;
		end else begin
			cross_vld_s1 <= cmd.cross_en;
			sq_vld_s1    <= cmd.sq_en;
			if (cmd.finish) begin
				if (!cmd.skip && differ) begin
					for (int i = 0; i < 3; i++) prev_q[i] <= res_q[i];
				end
				if (last_q) begin
					for (int i = 0; i < 3; i++) prev_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pts_ok_q <= in_data[15:0] >= 16'd3;
			last_q   <= in_last;
			for (int i = 0; i < 3; i++) begin
				ea_q[i] <= ea_d[i];
				eb_q[i] <= eb_d[i];
			end
		end
		prod_s1      <= mul_a * mul_b;
		cross_sel_s1 <= cmd.sel;
		if (cross_vld_s1) begin
			if (cross_sel_s1[0])
				n_q[cross_sel_s1[2:1]] <= n_q[cross_sel_s1[2:1]] - XW'(prod_s1);
			else
				n_q[cross_sel_s1[2:1]] <= XW'(prod_s1);
		end
		if (cmd.mag_load) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= mag_d[i];
				neg_q[i] <= n_q[i][XW-1];
			end
		end else if (cmd.norm_step) begin
			for (int i = 0; i < 3; i++) begin
				if (|or_w[MGW-1:MW]) mag_q[i] <= mag_q[i] >> 1;
				else mag_q[i] <= mag_q[i] << 1;
			end
		end
		sq_s1 <= sq_op * sq_op;
		if (cmd.acc_clr) acc_q <= '0;
		else if (cmd.sqrt_step) acc_q <= acc_q << 2;
		else if (sq_vld_s1) acc_q <= acc_q + SW'(sq_s1);
		if (cmd.sqrt_clr) begin
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			if (st >= strial) begin
				srem_q <= (RW+2)'(st - strial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				srem_q <= st[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			drem_q <= RW'(num[DNW-1:QW]);
			dlow_q <= num[QW-1:0];
			q_q    <= '0;
		end else if (cmd.div_step) begin
			dlow_q <= dlow_q << 1;
			if (dt >= {1'b0, root_q}) begin
				drem_q <= RW'(dt - {1'b0, root_q});
				q_q    <= {q_q[QW-2:0], 1'b1};
			end else begin
				drem_q <= dt[RW-1:0];
				q_q    <= {q_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.div_store) res_q[cmd.comp] <= neg_q[cmd.comp] ? OW'(-q_q) : OW'(q_q);
		if (cmd.finish) begin
			skipped_q <= cmd.skip;
			changed_q <= !cmd.skip && differ;
			for (int i = 0; i < 3; i++) outn_q[i] <= cmd.skip ? '0 : res_q[i];
		end
	end

	assign out_data = {outn_q[2], outn_q[1], outn_q[0]};
	assign out_user = {changed_q, skipped_q};

endmodule

// ----- src/fun_ctrl.sv -----
module fun_ctrl import fun_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output fun_cmd_t cmd,
	input  fun_sts_t sts
);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_CROSS  = 12'b000000000010,
		ST_MAG    = 12'b000000000100,
		ST_CHECK  = 12'b000000001000,
		ST_DSQ    = 12'b000000010000,
		ST_NORM   = 12'b000000100000,
		ST_SSQ    = 12'b000001000000,
		ST_SQRT   = 12'b000010000000,
		ST_DINIT  = 12'b000100000000,
		ST_DIV    = 12'b001000000000,
		ST_DSTORE = 12'b010000000000,
		ST_FINISH = 12'b100000000000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] comp_q, comp_d;
	logic       skip_q, skip_d;
	logic       valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q + 5'd1;
		comp_d  = comp_q;
		skip_d  = skip_q;
		cmd.comp = comp_q;
		cmd.skip = skip_q;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CROSS;
				end
			end
			ST_CROSS: begin
				cmd.cross_en = cnt_q < 5'd6;
				cmd.sel      = cnt_q[2:0];
				if (cnt_q == 5'd6) state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag_load = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.acc_clr = 1'b1;
				cnt_d       = '0;
				if (!sts.pts_ok || !sts.nz) begin
					skip_d  = 1'b1;
					state_d = ST_FINISH;
				end else if (sts.small_len) begin
					state_d = ST_DSQ;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_DSQ: begin
				cmd.sq_en = cnt_q < 5'd3;
				cmd.sel   = {1'b0, cnt_q[1:0]};
				if (cnt_q == 5'd4) begin
					if (sts.deg) begin
						skip_d  = 1'b1;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_NORM;
					end
				end
			end
			ST_NORM: begin
				cmd.acc_clr = 1'b1;
				cnt_d       = '0;
				if (sts.norm_done) state_d = ST_SSQ;
				else cmd.norm_step = 1'b1;
			end
			ST_SSQ: begin
				cmd.sq_en = cnt_q < 5'd3;
				cmd.sel   = {1'b0, cnt_q[1:0]};
				if (cnt_q == 5'd4) begin
					cmd.sqrt_clr = 1'b1;
					cnt_d        = '0;
					state_d      = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == 5'd31) begin
					comp_d  = '0;
					state_d = ST_DINIT;
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 5'd15) state_d = ST_DSTORE;
			end
			ST_DSTORE: begin
				cmd.div_store = 1'b1;
				if (comp_q == 2'd2) begin
					skip_d  = 1'b0;
					state_d = ST_FINISH;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = ST_DINIT;
				end
			end
			ST_FINISH: begin
				if (!valid_q || out_ready) begin
					cmd.finish = 1'b1;
					skip_d     = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			skip_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			skip_q  <= skip_d;
			if (cmd.finish) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

endmodule
